// File: sv/hpd_pkg.sv
// Shared types and constants for the heading PID differential drive unit.
// No dependencies; every other file refers to this package by scoped names.
package hpd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BASE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_BASE   = 3'd5;

  localparam logic [15:0] PROP_GAIN_RST  = 16'd384;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd154;
  localparam logic [15:0] DERIV_GAIN_RST = 16'd0;

  // stage registers an item passes through, input register to result register
  localparam int PIPE_DEPTH = 6;

  // largest and smallest 24-bit signed values
  localparam logic signed [24:0] SAT24_MAX = 25'sd8388607;
  localparam logic signed [24:0] SAT24_MIN = -25'sd8388608;

  localparam logic signed [15:0] HALF_TURN = 16'sd23040;

  typedef struct packed {
    logic        [15:0] prop_gain;
    logic        [15:0] integ_gain;
    logic        [15:0] deriv_gain;
    logic signed [16:0] target_heading;
    logic signed [20:0] right_base_speed;
    logic signed [20:0] left_base_speed;
  } hpd_cfg_t;

endpackage

// File: sv/heading_pid_differential_drive_unit.sv
// Heading PID with differential drive setpoints: top level and result register.
// Depends on hpd_pkg, hpd_cfg_regs, hpd_err_stage and hpd_corr_stage.
// Pipeline: six stage registers, from the input register to the result register.
// Throughput: one item per cycle while out_stall is low; each stage holds its item only while the next is full.
// Reset (synchronous, rst_n low): pipeline empty, integral and previous error zero,
// registers at their defaults.
module heading_pid_differential_drive_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [16:0]             in_measured_heading,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [23:0]             out_right_speed_setpoint,
  output logic signed [23:0]             out_left_speed_setpoint,
  output logic signed [23:0]             out_correction,
  output logic signed [15:0]             out_heading_error
);

  hpd_pkg::hpd_cfg_t  cfg;

  logic               e_valid, e_stall;
  logic signed [15:0] e_err;
  logic signed [16:0] e_dif;
  logic signed [23:0] e_integ;

  logic               c_valid, c_stall;
  logic signed [15:0] c_err;
  logic signed [23:0] c_corr;

  logic               out_valid_r;
  logic               en5;
  logic signed [23:0] right_r, left_r, corr_r;
  logic signed [15:0] err_r;
  logic signed [24:0] right_sum, left_sum;
  logic signed [23:0] right_nxt, left_nxt;

  hpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hpd_err_stage u_err (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_heading (in_measured_heading),
    .out_valid  (e_valid),
    .out_stall  (e_stall),
    .out_err    (e_err),
    .out_dif    (e_dif),
    .out_integ  (e_integ)
  );

  hpd_corr_stage u_corr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (e_valid),
    .in_stall  (e_stall),
    .in_err    (e_err),
    .in_dif    (e_dif),
    .in_integ  (e_integ),
    .out_valid (c_valid),
    .out_stall (c_stall),
    .out_err   (c_err),
    .out_corr  (c_corr)
  );

  assign en5     = !out_valid_r || !out_stall;
  assign c_stall = !en5;

  always_comb begin
    right_sum = 25'(cfg.right_base_speed) - 25'(c_corr);
    left_sum  = 25'(cfg.left_base_speed) + 25'(c_corr);
    if (right_sum > hpd_pkg::SAT24_MAX)      right_nxt = hpd_pkg::SAT24_MAX[23:0];
    else if (right_sum < hpd_pkg::SAT24_MIN) right_nxt = hpd_pkg::SAT24_MIN[23:0];
    else                                     right_nxt = right_sum[23:0];
    if (left_sum > hpd_pkg::SAT24_MAX)       left_nxt = hpd_pkg::SAT24_MAX[23:0];
    else if (left_sum < hpd_pkg::SAT24_MIN)  left_nxt = hpd_pkg::SAT24_MIN[23:0];
    else                                     left_nxt = left_sum[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en5) begin
      out_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && c_valid) begin
      right_r <= right_nxt;
      left_r  <= left_nxt;
      corr_r  <= c_corr;
      err_r   <= c_err;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_right_speed_setpoint = right_r;
  assign out_left_speed_setpoint  = left_r;
  assign out_correction           = corr_r;
  assign out_heading_error        = err_r;

endmodule

// File: sv/hpd_cfg_regs.sv
// Configuration register file of the heading PID unit.
// Depends on hpd_pkg for the register indexes, reset values and hpd_cfg_t.
module hpd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hpd_pkg::hpd_cfg_t              cfg
);

  hpd_pkg::hpd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain        <= hpd_pkg::PROP_GAIN_RST;
      cfg_r.integ_gain       <= hpd_pkg::INTEG_GAIN_RST;
      cfg_r.deriv_gain       <= hpd_pkg::DERIV_GAIN_RST;
      cfg_r.target_heading   <= '0;
      cfg_r.right_base_speed <= '0;
      cfg_r.left_base_speed  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hpd_pkg::REG_PROP_GAIN:   cfg_r.prop_gain        <= cfg_wdata[15:0];
        hpd_pkg::REG_INTEG_GAIN:  cfg_r.integ_gain       <= cfg_wdata[15:0];
        hpd_pkg::REG_DERIV_GAIN:  cfg_r.deriv_gain       <= cfg_wdata[15:0];
        hpd_pkg::REG_TARGET_HEAD: cfg_r.target_heading   <= $signed(cfg_wdata[16:0]);
        hpd_pkg::REG_RIGHT_BASE:  cfg_r.right_base_speed <= $signed(cfg_wdata[20:0]);
        hpd_pkg::REG_LEFT_BASE:   cfg_r.left_base_speed  <= $signed(cfg_wdata[20:0]);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/hpd_err_stage.sv
// Input register, heading error wrap and integral/previous-error state.
// Depends on hpd_pkg for hpd_cfg_t and the saturation limits.
module hpd_err_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hpd_pkg::hpd_cfg_t         cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [16:0]        in_heading,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [15:0]        out_err,
  output logic signed [16:0]        out_dif,
  output logic signed [23:0]        out_integ
);

  localparam logic signed [17:0] FULL_TURN  = 18'sd46080;
  localparam logic signed [17:0] TWO_TURNS  = 18'sd92160;
  localparam logic signed [17:0] HALF_TURN  = 18'sd23040;

  logic               v0_r, v1_r;
  logic signed [16:0] hd0_r;
  logic signed [15:0] err1_r;
  logic signed [16:0] dif1_r;
  logic signed [23:0] integ1_r;
  logic signed [23:0] integ_r;
  logic signed [15:0] prev_r;

  logic               en0, en1;
  logic signed [17:0] diff, rem, wrapped;
  logic signed [15:0] err_nxt;
  logic signed [16:0] dif_nxt;
  logic signed [24:0] integ_sum;
  logic signed [23:0] integ_nxt;

  assign en1      = !v1_r || !out_stall;
  assign en0      = !v0_r || en1;
  assign in_stall = !en0;

  always_comb begin
    diff = 18'(hd0_r) - 18'(cfg.target_heading);
    // truncating remainder: keeps the sign of the difference
    if (diff >= TWO_TURNS)        rem = diff - TWO_TURNS;
    else if (diff >= FULL_TURN)   rem = diff - FULL_TURN;
    else if (diff <= -TWO_TURNS)  rem = diff + TWO_TURNS;
    else if (diff <= -FULL_TURN)  rem = diff + FULL_TURN;
    else                          rem = diff;
    // exactly half a turn stays as it is
    if (rem > HALF_TURN)          wrapped = rem - FULL_TURN;
    else if (rem < -HALF_TURN)    wrapped = rem + FULL_TURN;
    else                          wrapped = rem;
    err_nxt = wrapped[15:0];
    dif_nxt = 17'(err_nxt) - 17'(prev_r);
    integ_sum = 25'(integ_r) + 25'(err_nxt);
    if (integ_sum > hpd_pkg::SAT24_MAX)      integ_nxt = hpd_pkg::SAT24_MAX[23:0];
    else if (integ_sum < hpd_pkg::SAT24_MIN) integ_nxt = hpd_pkg::SAT24_MIN[23:0];
    else                                     integ_nxt = integ_sum[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) begin
        v1_r <= v0_r;
        if (v0_r) begin
          integ_r <= integ_nxt;
          prev_r  <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) hd0_r <= in_heading;
    if (en1 && v0_r) begin
      err1_r   <= err_nxt;
      dif1_r   <= dif_nxt;
      integ1_r <= integ_nxt;
    end
  end

  assign out_valid = v1_r;
  assign out_err   = err1_r;
  assign out_dif   = dif1_r;
  assign out_integ = integ1_r;

endmodule

// File: sv/hpd_corr_stage.sv
// Gain products, weighted sum, rounding and divide-by-5120 of the PID correction.
// Depends on hpd_pkg for hpd_cfg_t.
module hpd_corr_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  hpd_pkg::hpd_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_err,
  input  logic signed [16:0]  in_dif,
  input  logic signed [23:0]  in_integ,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_err,
  output logic signed [23:0]  out_corr
);

  localparam logic signed [47:0] ROUND_BIAS = 48'sd2560;
  // bounds of floor((N+2560)/1024) that keep the quotient by 5 inside 24 bits
  localparam logic signed [47:0] QSUM_MAX   = 48'sd41943039;
  localparam logic signed [47:0] QSUM_MIN   = -48'sd41943040;
  localparam logic        [57:0] DIV5_MAGIC = 58'h0_CCCC_CCCD;

  logic               v2_r, v3_r, v4_r;
  logic               en2, en3, en4;
  logic signed [15:0] err2_r, err3_r, err4_r;
  logic signed [32:0] p2_r;
  logic signed [40:0] i2_r;
  logic signed [33:0] d2_r;
  logic        [26:0] m3_r;
  logic signed [23:0] corr4_r;

  logic signed [32:0] p_nxt;
  logic signed [40:0] i_nxt;
  logic signed [33:0] d_nxt;
  logic signed [47:0] p_x, i_x, d_x, sum, qsum, qsum_sat, qoff;
  logic        [26:0] m_nxt;
  logic        [57:0] prod;
  logic        [23:0] quot;
  logic signed [23:0] corr_nxt;

  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign in_stall = !en2;

  always_comb begin
    p_nxt = $signed({1'b0, cfg.prop_gain})  * in_err;
    i_nxt = $signed({1'b0, cfg.integ_gain}) * in_integ;
    d_nxt = $signed({1'b0, cfg.deriv_gain}) * in_dif;
  end

  // N = 20*kp*e + ki*I + 400*kd*de, then floor((N+2560)/1024), clamped and offset
  always_comb begin
    p_x  = 48'(p2_r);
    i_x  = 48'(i2_r);
    d_x  = 48'(d2_r);
    sum  = (p_x <<< 4) + (p_x <<< 2) + i_x + (d_x <<< 8) + (d_x <<< 7) + (d_x <<< 4)
           + ROUND_BIAS;
    qsum = sum >>> 10;
    if (qsum > QSUM_MAX)      qsum_sat = QSUM_MAX;
    else if (qsum < QSUM_MIN) qsum_sat = QSUM_MIN;
    else                      qsum_sat = qsum;
    qoff  = qsum_sat - QSUM_MIN;
    m_nxt = qoff[26:0];
  end

  // exact divide by 5 through the reciprocal; removing the offset flips the top bit
  always_comb begin
    prod     = 58'(m3_r) * DIV5_MAGIC;
    quot     = prod[57:34];
    corr_nxt = $signed({~quot[23], quot[22:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en2) v2_r <= in_valid;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && in_valid) begin
      err2_r <= in_err;
      p2_r   <= p_nxt;
      i2_r   <= i_nxt;
      d2_r   <= d_nxt;
    end
    if (en3 && v2_r) begin
      err3_r <= err2_r;
      m3_r   <= m_nxt;
    end
    if (en4 && v3_r) begin
      err4_r  <= err3_r;
      corr4_r <= corr_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_err   = err4_r;
  assign out_corr  = corr4_r;

endmodule

// File: sv/hpd_checker.sv
// Port-level checks for heading_pid_differential_drive_unit, attached by bind.
// Depends on hpd_pkg for the pipeline depth and the half-turn limit.
module hpd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [23:0]             out_right_speed_setpoint,
  input logic signed [23:0]             out_left_speed_setpoint,
  input logic signed [23:0]             out_correction,
  input logic signed [15:0]             out_heading_error
);

  localparam int CNT_W = $clog2(hpd_pkg::PIPE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // items in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CNT_W'(in_xfer) - CNT_W'(out_xfer);
    end
  end

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_error <= hpd_pkg::HALF_TURN) &&
                  (out_heading_error >= -hpd_pkg::HALF_TURN))
    else $error("heading error outside half a turn");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_correction) &&
                               $stable(out_right_speed_setpoint) &&
                               $stable(out_left_speed_setpoint) &&
                               $stable(out_heading_error))
    else $error("stalled result changed");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output side drains");

  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cnt_r) <= hpd_pkg::PIPE_DEPTH) && (!out_valid || cnt_r != '0))
    else $error("result without a matching input transfer");

endmodule

bind heading_pid_differential_drive_unit hpd_checker u_hpd_checker (.*);

// File: tb/sv/hpd_checker.sv
// Result checker for the heading PID differential drive unit.
// Follows register writes and input transfers, predicts each result and compares it.
// Depends on hpd_pkg for register indexes, reset values and saturation limits.
module hpd_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [16:0]             in_measured_heading,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [23:0]             out_right_speed_setpoint,
  input  logic signed [23:0]             out_left_speed_setpoint,
  input  logic signed [23:0]             out_correction,
  input  logic signed [15:0]             out_heading_error,
  output int                             fail_count,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FULL_TURN = 46080;
  localparam longint HALF_TURN = hpd_pkg::HALF_TURN;

  typedef struct packed {
    logic signed [23:0] right_sp;
    logic signed [23:0] left_sp;
    logic signed [23:0] corr;
    logic signed [15:0] err;
  } drive_result_t;

  hpd_pkg::hpd_cfg_t regs;
  longint            integral_acc;
  longint            last_err;
  drive_result_t     pending_drive[$];

  function automatic longint sat24(longint v);
    if (v > hpd_pkg::SAT24_MAX) return longint'(hpd_pkg::SAT24_MAX);
    if (v < hpd_pkg::SAT24_MIN) return longint'(hpd_pkg::SAT24_MIN);
    return v;
  endfunction

  // one control tick: wrapped error, integral, correction and both setpoints
  function automatic drive_result_t predict_drive(logic signed [16:0] yaw);
    longint        e;
    longint        num;
    longint        q;
    longint        c;
    drive_result_t r;
    e = (longint'(yaw) - longint'($signed(regs.target_heading))) % FULL_TURN;
    // an error of exactly half a turn keeps its sign
    if (e > HALF_TURN) e -= FULL_TURN;
    else if (e < -HALF_TURN) e += FULL_TURN;
    integral_acc = sat24(integral_acc + e);
    num = 20 * longint'(regs.prop_gain) * e
        + longint'(regs.integ_gain) * integral_acc
        + 400 * longint'(regs.deriv_gain) * (e - last_err);
    // round half up: floor((num + 2560) / 5120)
    q = (num + 2560) / 5120;
    if ((num + 2560) % 5120 < 0) q -= 1;
    c = sat24(q);
    r.right_sp = 24'(sat24(longint'($signed(regs.right_base_speed)) - c));
    r.left_sp  = 24'(sat24(longint'($signed(regs.left_base_speed)) + c));
    r.corr     = 24'(c);
    r.err      = 16'(e);
    last_err   = e;
    return r;
  endfunction

  function automatic void compare_field(string label, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    if (!rst_n) begin
      regs.prop_gain        = hpd_pkg::PROP_GAIN_RST;
      regs.integ_gain       = hpd_pkg::INTEG_GAIN_RST;
      regs.deriv_gain       = hpd_pkg::DERIV_GAIN_RST;
      regs.target_heading   = '0;
      regs.right_base_speed = '0;
      regs.left_base_speed  = '0;
      integral_acc = 0;
      last_err     = 0;
      pending_drive.delete();
      fail_count   = 0;
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          hpd_pkg::REG_PROP_GAIN:   regs.prop_gain        = cfg_wdata[15:0];
          hpd_pkg::REG_INTEG_GAIN:  regs.integ_gain       = cfg_wdata[15:0];
          hpd_pkg::REG_DERIV_GAIN:  regs.deriv_gain       = cfg_wdata[15:0];
          hpd_pkg::REG_TARGET_HEAD: regs.target_heading   = cfg_wdata[16:0];
          hpd_pkg::REG_RIGHT_BASE:  regs.right_base_speed = cfg_wdata[20:0];
          hpd_pkg::REG_LEFT_BASE:   regs.left_base_speed  = cfg_wdata[20:0];
          default: ;
        endcase
      end
      // results leave in order, so an output transfer is checked before this cycle's input
      if (out_valid && !out_stall) begin
        if (pending_drive.size() == 0) begin
          $display("%0t: unexpected result, right %0d left %0d correction %0d error %0d",
                   $time, out_right_speed_setpoint, out_left_speed_setpoint,
                   out_correction, out_heading_error);
          fail_count++;
        end else begin
          want = pending_drive.pop_front();
          compare_field("right_speed_setpoint", want.right_sp, out_right_speed_setpoint);
          compare_field("left_speed_setpoint", want.left_sp, out_left_speed_setpoint);
          compare_field("correction", want.corr, out_correction);
          compare_field("heading_error", want.err, out_heading_error);
        end
      end
      if (in_valid && !in_stall) pending_drive.push_back(predict_drive(in_measured_heading));
      outstanding <= pending_drive.size();
    end
  end

endmodule

// File: tb/sv/heading_pid_differential_drive_unit_tb.sv
// Testbench top for the heading PID differential drive unit: clock, reset, register
// settings, heading stimulus and receiver stalls, with the verdict at the end.
// Depends on hpd_pkg, hpd_result_checker and the unit under test.
module heading_pid_differential_drive_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF   = 4 * hpd_pkg::PIPE_DEPTH;

  typedef enum {SWEEP, TRACK, WINDUP} heading_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [hpd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [16:0]             in_measured_heading = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [23:0]             out_right_speed_setpoint;
  logic signed [23:0]             out_left_speed_setpoint;
  logic signed [23:0]             out_correction;
  logic signed [15:0]             out_heading_error;
  int                             fail_count;
  int                             outstanding;

  bit steady = 1'b0;     // no idling on either side
  int quiet_cycles = 0;

  // wrap boundaries, full turns and the extremes of the 17-bit field
  int probe_yaw[$] = '{0, 23040, -23040, 23041, -23041, 46080, -46080, 65535, -65536,
                       1, -1, 40000};

  heading_pid_differential_drive_unit i_dut (.*);
  hpd_result_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [20:0] pick_speed();
    case ($urandom_range(0, 5))
      0: return 21'h100000;
      1: return 21'h0FFFFF;
      default: return 21'($urandom);
    endcase
  endfunction

  // tame keeps the target within half a turn so that offsets stay inside the field
  function automatic hpd_pkg::hpd_cfg_t random_settings(bit tame);
    hpd_pkg::hpd_cfg_t s;
    s.prop_gain  = pick_gain();
    s.integ_gain = pick_gain();
    s.deriv_gain = pick_gain();
    if (tame) begin
      s.target_heading = 17'(int'($urandom_range(0, 40000)) - 20000);
    end else begin
      case ($urandom_range(0, 4))
        0: s.target_heading = -17'sd46080;
        1: s.target_heading = 17'sd46080;
        2: s.target_heading = 17'($urandom);
        default: s.target_heading = 17'(int'($urandom_range(0, 92160)) - 46080);
      endcase
    end
    s.right_base_speed = pick_speed();
    s.left_base_speed  = pick_speed();
    return s;
  endfunction

  task automatic write_reg(logic [hpd_pkg::CFG_IDX_W-1:0] idx,
                           logic [hpd_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // junk in the unused upper bits and a write past the last register, both to be ignored
  task automatic program_regs(hpd_pkg::hpd_cfg_t s);
    write_reg(hpd_pkg::REG_PROP_GAIN, {5'($urandom), s.prop_gain});
    write_reg(hpd_pkg::REG_INTEG_GAIN, {5'($urandom), s.integ_gain});
    write_reg(hpd_pkg::REG_DERIV_GAIN, {5'($urandom), s.deriv_gain});
    write_reg(hpd_pkg::REG_TARGET_HEAD, {4'($urandom), s.target_heading});
    write_reg(hpd_pkg::REG_RIGHT_BASE, s.right_base_speed);
    write_reg(hpd_pkg::REG_LEFT_BASE, s.left_base_speed);
    write_reg(3'(hpd_pkg::REG_LEFT_BASE + 1 + $urandom_range(0, 1)), 21'($urandom));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_heading(logic signed [16:0] yaw);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measured_heading <= yaw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_probes();
    foreach (probe_yaw[i]) send_heading(17'(probe_yaw[i]));
    in_valid <= 1'b0;
    wait_results();
  endtask

  task automatic run_phase(hpd_pkg::hpd_cfg_t s, heading_mode_t mode, int count, int sign);
    int                 off;
    logic signed [16:0] yaw;
    program_regs(s);
    for (int k = 0; k < count; k++) begin
      case (mode)
        SWEEP: yaw = 17'($urandom);
        TRACK: begin
          off = int'($urandom_range(0, 6000)) - 3000;
          if ($urandom_range(0, 9) == 0) off += $urandom_range(0, 1) ? 46080 : -46080;
          yaw = 17'(int'($signed(s.target_heading)) + off);
        end
        default: begin
          // steady one-sided error to drive the integral into saturation
          off = sign * int'($urandom_range(21000, 23040));
          yaw = 17'(int'($signed(s.target_heading)) + off);
        end
      endcase
      send_heading(yaw);
    end
    in_valid <= 1'b0;
    wait_results();
  endtask

  initial begin
    hpd_pkg::hpd_cfg_t s;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_probes();
    s.prop_gain        = 16'hFFFF;
    s.integ_gain       = 16'hFFFF;
    s.deriv_gain       = 16'hFFFF;
    s.target_heading   = -17'sd46080;
    s.right_base_speed = 21'h0FFFFF;
    s.left_base_speed  = 21'h100000;
    program_regs(s);
    send_probes();

    for (int p = 0; p < 12; p++) begin
      steady = (p == 2);
      case (p)
        2: run_phase(random_settings(1'b1), WINDUP, 420, 1);
        8: run_phase(random_settings(1'b1), WINDUP, 800, -1);
        5: begin
          s.prop_gain        = 16'd0;
          s.integ_gain       = 16'd0;
          s.deriv_gain       = 16'd0;
          s.target_heading   = 17'sd46080;
          s.right_base_speed = 21'h100000;
          s.left_base_speed  = 21'h0FFFFF;
          run_phase(s, SWEEP, 45, 0);
        end
        default: run_phase(random_settings(1'b0), (p % 2) ? TRACK : SWEEP, 45, 0);
      endcase
    end

    repeat (HOLD_OFF) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
sv/hpd_pkg.sv
sv/hpd_cfg_regs.sv
sv/hpd_err_stage.sv
sv/hpd_corr_stage.sv
sv/heading_pid_differential_drive_unit.sv
sv/hpd_checker.sv
tb/sv/hpd_checker.sv
tb/sv/heading_pid_differential_drive_unit_tb.sv
